FILE: rtl/core/mf3_pkg.sv
// Package for the 3x3 mean filter: result record, register indexes and constants.
// Shared by mf3_out_queue and mean_filter_3x3_interleaved; depends on nothing.
package mf3_pkg;

    localparam int COL_W     = 13;
    localparam int ROW_W     = 16;
    localparam int CHAN_W    = 2;
    localparam int CHAN_SLOTS = 4;
    localparam int CSUM_W    = 10;
    localparam int SUM_W     = 12;
    localparam int Q_DEPTH   = 8;
    localparam int Q_PTR_W   = 3;
    localparam int Q_CNT_W   = 4;
    localparam int RES_SLOTS = 4;

    localparam logic [SUM_W-1:0] ROUND_BIAS  = 12'd5;
    localparam logic [12:0]      DIV9_RECIP  = 13'd7282;

    localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             row_end;
        logic             frame_end;
        logic             last;
    } t_res;

    // floor((sum + 5) / 9) by a reciprocal; exact for sums up to 9 * 255.
    function automatic logic [7:0] mean_of(input logic [SUM_W-1:0] sum);
        logic [24:0] prod;
        prod = 25'(sum + ROUND_BIAS) * 25'(DIV9_RECIP);
        return prod[23:16];
    endfunction

endpackage

FILE: rtl/core/mean_filter_3x3_interleaved.sv
// Top level of the 3x3 mean filter over an interleaved 8-bit raster stream.
// Accepts one sample per cycle when not stalled; the line stores are read at acceptance and written
// in the next cycle. Results pass the stage-two register and the queue to the output register.
// The output hands out one result per ready cycle, so inputs giving several results (last column,
// last row) stall the input while queued and staged results exceed half the eight-entry queue.
// Reset clears counters, column sums and the queue and loads defaults; line stores are not cleared.
module mean_filter_3x3_interleaved #(
    parameter int MAX_WIDTH    = 2048,
    parameter int MAX_CHANNELS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_sample,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_mean_value,
    output logic        o_row_end,
    output logic        o_frame_end,
    output logic        o_last
);
    import mf3_pkg::*;

    localparam int LINE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
    localparam int AW         = $clog2(LINE_DEPTH);
    localparam int WIDTH_W    = $clog2(MAX_WIDTH + 1);
    localparam int RLEN_W     = WIDTH_W + 3;

    typedef struct packed {
        logic [7:0]        cur;
        logic [CHAN_W-1:0] ch;
        logic [AW-1:0]     addr;
        logic              in_store;
        logic              first_col;
        logic              last_col;
        logic              last_chan;
        logic              top;
        logic              last_row;
    } t_stage;

    logic [11:0]        r_image_width;
    logic [15:0]        r_image_height;
    logic [2:0]         r_channel_count;

    logic [7:0]         r_line_two_back [LINE_DEPTH];
    logic [7:0]         r_line_one_back [LINE_DEPTH];
    logic [7:0]         r_rd_two;
    logic [7:0]         r_rd_one;

    logic [CSUM_W-1:0]  r_win0 [CHAN_SLOTS];
    logic [CSUM_W-1:0]  r_win1 [CHAN_SLOTS];
    logic [CSUM_W-1:0]  r_lw0  [CHAN_SLOTS];
    logic [CSUM_W-1:0]  r_lw1  [CHAN_SLOTS];

    logic [ROW_W-1:0]   r_row_count;
    logic [COL_W-1:0]   r_byte_col;
    logic [CHAN_W-1:0]  r_chan_index;
    logic               r_s2_valid;
    t_stage             r_s2;

    logic [WIDTH_W-1:0] eff_w;
    logic [15:0]        eff_h;
    logic [2:0]         eff_c;
    logic [RLEN_W-1:0]  row_len;
    logic [RLEN_W-1:0]  last_col_pos;
    logic               in_accept;
    t_stage             n_s2;
    logic               row_wrap;

    logic [7:0]         a_val;
    logic [7:0]         b_val;
    logic [CSUM_W-1:0]  s_col;
    logic [CSUM_W-1:0]  s_last;
    logic [CSUM_W-1:0]  w0;
    logic [CSUM_W-1:0]  w1;
    logic [CSUM_W-1:0]  w0_n;
    logic [CSUM_W-1:0]  lw0;
    logic [CSUM_W-1:0]  lw1;
    logic [CSUM_W-1:0]  lw0_n;
    logic [RES_SLOTS-1:0] push;
    t_res [RES_SLOTS-1:0] cand;
    logic [2:0]         n_push;
    logic [Q_CNT_W-1:0] q_count;

    always_comb begin
        if (r_image_width < 12'd2) begin
            eff_w = WIDTH_W'(2);
        end else if (32'(r_image_width) > MAX_WIDTH) begin
            eff_w = WIDTH_W'(MAX_WIDTH);
        end else begin
            eff_w = WIDTH_W'(r_image_width);
        end
        eff_h = (r_image_height < 16'd2) ? 16'd2 : r_image_height;
        if (r_channel_count == 3'd0) begin
            eff_c = 3'd1;
        end else if (32'(r_channel_count) > MAX_CHANNELS) begin
            eff_c = 3'(MAX_CHANNELS);
        end else begin
            eff_c = r_channel_count;
        end
        row_len      = RLEN_W'(eff_w) * RLEN_W'(eff_c);
        last_col_pos = RLEN_W'(eff_w - WIDTH_W'(1)) * RLEN_W'(eff_c);
    end

    always_comb begin
        in_accept       = i_in_valid && o_in_ready;
        n_s2.cur        = i_sample;
        n_s2.ch         = r_chan_index;
        n_s2.addr       = AW'(r_byte_col);
        n_s2.in_store   = 32'(r_byte_col) < LINE_DEPTH;
        n_s2.first_col  = 32'(r_byte_col) < 32'(eff_c);
        n_s2.last_col   = 32'(r_byte_col) >= 32'(last_col_pos);
        n_s2.last_chan  = 32'(r_chan_index) >= 32'(eff_c) - 32'd1;
        n_s2.top        = r_row_count == '0;
        n_s2.last_row   = 32'(r_row_count) >= 32'(eff_h) - 32'd1;
        row_wrap        = 32'(r_byte_col) + 32'd1 >= 32'(row_len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width   <= 12'd2048;
            r_image_height  <= 16'd2;
            r_channel_count <= 3'd1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH: begin
                    r_image_width <= i_cfg_data[11:0];
                end
                REG_IMAGE_HEIGHT: begin
                    r_image_height <= i_cfg_data;
                end
                REG_CHANNEL_COUNT: begin
                    r_channel_count <= i_cfg_data[2:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count  <= '0;
            r_byte_col   <= '0;
            r_chan_index <= '0;
            r_s2_valid   <= 1'b0;
        end else begin
            r_s2_valid <= in_accept;
            if (in_accept) begin
                if (row_wrap) begin
                    r_byte_col   <= '0;
                    r_chan_index <= '0;
                    if (32'(r_row_count) + 32'd1 >= 32'(eff_h)) begin
                        r_row_count <= '0;
                    end else begin
                        r_row_count <= ROW_W'(r_row_count + 1'b1);
                    end
                end else begin
                    r_byte_col <= COL_W'(r_byte_col + 1'b1);
                    if (3'(r_chan_index) + 3'd1 >= eff_c) begin
                        r_chan_index <= '0;
                    end else begin
                        r_chan_index <= CHAN_W'(r_chan_index + 1'b1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s2     <= n_s2;
            r_rd_two <= r_line_two_back[n_s2.addr];
            r_rd_one <= r_line_one_back[n_s2.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_valid && r_s2.in_store) begin
            r_line_two_back[r_s2.addr] <= r_s2.top ? r_s2.cur : r_rd_one;
            r_line_one_back[r_s2.addr] <= r_s2.cur;
        end
    end

    always_comb begin
        a_val  = r_s2.in_store ? r_rd_two : 8'd0;
        b_val  = r_s2.in_store ? r_rd_one : 8'd0;
        s_col  = CSUM_W'(a_val) + CSUM_W'(b_val) + CSUM_W'(r_s2.cur);
        s_last = CSUM_W'(b_val) + (CSUM_W'(r_s2.cur) << 1);
        w0     = r_win0[r_s2.ch];
        w1     = r_win1[r_s2.ch];
        lw0    = r_lw0[r_s2.ch];
        lw1    = r_lw1[r_s2.ch];
        w0_n   = r_s2.first_col ? s_col : w1;
        lw0_n  = r_s2.first_col ? s_last : lw1;

        push[0] = r_s2_valid && !r_s2.top && !r_s2.first_col;
        push[1] = r_s2_valid && !r_s2.top && r_s2.last_col;
        push[2] = r_s2_valid && !r_s2.top && r_s2.last_row && !r_s2.first_col;
        push[3] = r_s2_valid && !r_s2.top && r_s2.last_row && r_s2.last_col;

        cand[0].sum       = SUM_W'(w0) + SUM_W'(w1) + SUM_W'(s_col);
        cand[0].row_end   = 1'b0;
        cand[0].frame_end = 1'b0;
        cand[1].sum       = SUM_W'(w0_n) + (SUM_W'(s_col) << 1);
        cand[1].row_end   = r_s2.last_chan;
        cand[1].frame_end = 1'b0;
        cand[2].sum       = SUM_W'(lw0) + SUM_W'(lw1) + SUM_W'(s_last);
        cand[2].row_end   = 1'b0;
        cand[2].frame_end = 1'b0;
        cand[3].sum       = SUM_W'(lw0_n) + (SUM_W'(s_last) << 1);
        cand[3].row_end   = r_s2.last_chan;
        cand[3].frame_end = r_s2.last_chan;

        cand[3].last = push[3];
        cand[2].last = push[2] && !push[3];
        cand[1].last = push[1] && !push[2] && !push[3];
        cand[0].last = push[0] && !push[1] && !push[2] && !push[3];

        n_push = 3'(push[0]) + 3'(push[1]) + 3'(push[2]) + 3'(push[3]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CHAN_SLOTS; k++) begin
                r_win0[k] <= '0;
                r_win1[k] <= '0;
                r_lw0[k]  <= '0;
                r_lw1[k]  <= '0;
            end
        end else if (r_s2_valid && !r_s2.top) begin
            r_win0[r_s2.ch] <= w0_n;
            r_win1[r_s2.ch] <= s_col;
            if (r_s2.last_row) begin
                r_lw0[r_s2.ch] <= lw0_n;
                r_lw1[r_s2.ch] <= s_last;
            end
        end
    end

    // The queue must keep room for the pushes now in flight plus those of the next transaction.
    assign o_in_ready = (5'(q_count) + 5'(n_push)) <= 5'(Q_DEPTH - RES_SLOTS);

    mf3_out_queue u_out_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_data  (cand),
        .o_count      (q_count),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_mean_value (o_mean_value),
        .o_row_end    (o_row_end),
        .o_frame_end  (o_frame_end),
        .o_last       (o_last)
    );

endmodule

FILE: rtl/core/mf3_out_queue.sv
// Result queue and output register of the 3x3 mean filter.
// Takes up to four results per cycle and hands out one per transaction; uses mf3_pkg.
module mf3_out_queue (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic [mf3_pkg::RES_SLOTS-1:0]             i_push,
    input  mf3_pkg::t_res [mf3_pkg::RES_SLOTS-1:0]    i_push_data,
    output logic [mf3_pkg::Q_CNT_W-1:0]               o_count,
    output logic                                      o_out_valid,
    input  logic                                      i_out_ready,
    output logic [7:0]                                o_mean_value,
    output logic                                      o_row_end,
    output logic                                      o_frame_end,
    output logic                                      o_last
);
    import mf3_pkg::*;

    t_res                 r_queue [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wptr;
    logic [Q_PTR_W-1:0]   r_rptr;
    logic [Q_CNT_W-1:0]   r_count;
    logic                 r_out_valid;
    logic [7:0]           r_mean;
    logic                 r_row_end;
    logic                 r_frame_end;
    logic                 r_last;

    logic [Q_PTR_W-1:0]   offs [RES_SLOTS];
    logic [Q_PTR_W-1:0]   n_push;
    logic                 pop;
    t_res                 head;

    always_comb begin
        n_push = '0;
        for (int k = 0; k < RES_SLOTS; k++) begin
            offs[k] = n_push;
            n_push  = n_push + Q_PTR_W'(i_push[k]);
        end
        pop  = (r_count != '0) && (!r_out_valid || i_out_ready);
        head = r_queue[r_rptr];
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < RES_SLOTS; k++) begin
            if (i_push[k]) begin
                r_queue[Q_PTR_W'(r_wptr + offs[k])] <= i_push_data[k];
            end
        end
        if (pop) begin
            r_mean      <= mean_of(head.sum);
            r_row_end   <= head.row_end;
            r_frame_end <= head.frame_end;
            r_last      <= head.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr      <= '0;
            r_rptr      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_wptr  <= Q_PTR_W'(r_wptr + n_push);
            r_rptr  <= Q_PTR_W'(r_rptr + Q_PTR_W'(pop));
            r_count <= Q_CNT_W'(r_count + Q_CNT_W'(n_push) - Q_CNT_W'(pop));
            if (pop) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_count      = r_count;
    assign o_out_valid  = r_out_valid;
    assign o_mean_value = r_mean;
    assign o_row_end    = r_row_end;
    assign o_frame_end  = r_frame_end;
    assign o_last       = r_last;

endmodule

FILE: tb/mf3_mean_check.sv
// Scoreboard for the 3x3 mean filter: mirrors the register writes, predicts the means of
// every accepted sample and compares each accepted result with the oldest prediction.
// Depends on mf3_pkg for the register indexes and the rounding constant.
module mf3_mean_check #(
    parameter int MAX_WIDTH    = 2048,
    parameter int MAX_CHANNELS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_sample,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_mean_value,
    input  logic        i_row_end,
    input  logic        i_frame_end,
    input  logic        i_last,
    output int          o_failures,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import mf3_pkg::*;

    localparam int LINE_DEPTH = MAX_WIDTH * MAX_CHANNELS;

    typedef struct packed {
        logic [7:0] mean_value;
        logic       row_end;
        logic       frame_end;
        logic       last;
    } t_mean_result;

    logic [11:0] width_reg;
    logic [15:0] height_reg;
    logic [2:0]  chan_reg;

    bit [7:0]    line_two_back [LINE_DEPTH];
    bit [7:0]    line_one_back [LINE_DEPTH];
    int unsigned col_win  [CHAN_SLOTS][2];
    int unsigned last_win [CHAN_SLOTS][2];
    int unsigned row_cnt;
    int unsigned byte_pos;
    int unsigned chan_idx;

    t_mean_result expected_means [$];
    t_mean_result oldest;
    int           failures = 0;

    function automatic t_mean_result make_result(input int unsigned sum, input logic row_end,
                                                 input logic frame_end);
        t_mean_result r;
        r.mean_value = 8'((sum + int'(ROUND_BIAS)) / 9);
        r.row_end    = row_end;
        r.frame_end  = frame_end;
        r.last       = 1'b0;
        return r;
    endfunction

    task automatic predict_means(input logic [7:0] cur);
        int unsigned  w, h, c, ch, pos, a, b, s, s2;
        bit           in_store, first_col, last_col, last_chan, top_row, last_row;
        t_mean_result res [4];
        int           n;
        w = 32'(width_reg);
        if (w < 2) w = 2;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        h = (height_reg < 16'd2) ? 2 : 32'(height_reg);
        c = 32'(chan_reg);
        if (c < 1) c = 1;
        if (c > MAX_CHANNELS) c = MAX_CHANNELS;
        ch        = chan_idx & 3;
        pos       = byte_pos;
        in_store  = pos < LINE_DEPTH;
        first_col = pos < c;
        last_col  = pos >= (w - 1) * c;
        last_chan = chan_idx >= c - 1;
        top_row   = row_cnt == 0;
        last_row  = row_cnt >= h - 1;
        a = in_store ? 32'(line_two_back[pos]) : 0;
        b = in_store ? 32'(line_one_back[pos]) : 0;
        n = 0;

        if (!top_row) begin
            s = a + b + cur;
            if (first_col) begin
                col_win[ch][0] = s;
                col_win[ch][1] = s;
            end else begin
                res[n] = make_result(col_win[ch][0] + col_win[ch][1] + s, 1'b0, 1'b0);
                n++;
                col_win[ch][0] = col_win[ch][1];
                col_win[ch][1] = s;
            end
            if (last_col) begin
                res[n] = make_result(col_win[ch][0] + 2 * col_win[ch][1], last_chan, 1'b0);
                n++;
            end
            if (last_row) begin
                s2 = b + 2 * cur;
                if (first_col) begin
                    last_win[ch][0] = s2;
                    last_win[ch][1] = s2;
                end else begin
                    res[n] = make_result(last_win[ch][0] + last_win[ch][1] + s2, 1'b0, 1'b0);
                    n++;
                    last_win[ch][0] = last_win[ch][1];
                    last_win[ch][1] = s2;
                end
                if (last_col) begin
                    res[n] = make_result(last_win[ch][0] + 2 * last_win[ch][1], last_chan,
                                         last_chan);
                    n++;
                end
            end
        end

        if (in_store) begin
            line_two_back[pos] = top_row ? cur : 8'(b);
            line_one_back[pos] = cur;
        end

        chan_idx = (chan_idx + 1 >= c) ? 0 : chan_idx + 1;
        if (pos + 1 >= w * c) begin
            byte_pos = 0;
            chan_idx = 0;
            row_cnt  = (row_cnt + 1 >= h) ? 0 : row_cnt + 1;
        end else begin
            byte_pos = (pos + 1) & 32'h1FFF;
        end

        if (n > 0) res[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) expected_means.push_back(res[i]);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  = 12'd2048;
            height_reg = 16'd2;
            chan_reg   = 3'd1;
            row_cnt    = 0;
            byte_pos   = 0;
            chan_idx   = 0;
            for (int i = 0; i < CHAN_SLOTS; i++) begin
                col_win[i]  = '{0, 0};
                last_win[i] = '{0, 0};
            end
            expected_means.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_IMAGE_WIDTH: begin
                        width_reg = i_cfg_data[11:0];
                    end
                    REG_IMAGE_HEIGHT: begin
                        height_reg = i_cfg_data;
                    end
                    REG_CHANNEL_COUNT: begin
                        chan_reg = i_cfg_data[2:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_means.size() == 0) begin
                    $error("unexpected result transaction: mean_value %0d", i_mean_value);
                    failures++;
                end else begin
                    oldest = expected_means.pop_front();
                    if (i_mean_value !== oldest.mean_value) begin
                        $error("mean_value: expected %0d, actual %0d", oldest.mean_value,
                               i_mean_value);
                        failures++;
                    end
                    if (i_row_end !== oldest.row_end) begin
                        $error("row_end: expected %0d, actual %0d", oldest.row_end, i_row_end);
                        failures++;
                    end
                    if (i_frame_end !== oldest.frame_end) begin
                        $error("frame_end: expected %0d, actual %0d", oldest.frame_end,
                               i_frame_end);
                        failures++;
                    end
                    if (i_last !== oldest.last) begin
                        $error("last: expected %0d, actual %0d", oldest.last, i_last);
                        failures++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) predict_means(i_sample);
        end
        o_failures <= failures;
        o_pending  <= expected_means.size();
    end

endmodule

FILE: tb/tb_mean_filter_3x3_interleaved.sv
// Top of the 3x3 mean filter testbench: drives frames of random and directed samples through
// a sweep of register settings with random gaps on both channels and reports the verdict.
// Depends on mf3_pkg, mean_filter_3x3_interleaved and the mf3_mean_check scoreboard.
module tb_mean_filter_3x3_interleaved;
    timeunit 1ns;
    timeprecision 1ps;

    import mf3_pkg::*;

    localparam logic [1:0] REG_SPARE  = 2'd3;
    localparam int         IDLE_LIMIT = 2000;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data  = '0;
    logic        i_in_valid  = 1'b0;
    logic [7:0]  i_sample    = '0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [7:0]  o_mean_value;
    logic        o_row_end;
    logic        o_frame_end;
    logic        o_last;

    int failures;
    int pending;
    int samples_sent = 0;
    int random_samples = 0;
    int means_seen = 0;
    int frames_run = 0;
    int idle_cycles = 0;
    int in_run_left = 0;
    int out_run_left = 0;
    bit in_run_idle = 1'b0;
    bit out_run_idle = 1'b0;

    mean_filter_3x3_interleaved DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_sample     (i_sample),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_mean_value (o_mean_value),
        .o_row_end    (o_row_end),
        .o_frame_end  (o_frame_end),
        .o_last       (o_last)
    );

    mf3_mean_check u_mean_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_sample     (i_sample),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_mean_value (o_mean_value),
        .i_row_end    (o_row_end),
        .i_frame_end  (o_frame_end),
        .i_last       (o_last),
        .o_failures   (failures),
        .o_pending    (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int next_gap(inout int run_left, inout bit run_idle);
        if (run_left == 0) begin
            run_left = int'($urandom_range(1, 24));
            run_idle = 1'($urandom_range(0, 1));
        end
        run_left--;
        return run_idle ? int'($urandom_range(0, 11)) : 0;
    endfunction

    function automatic logic [7:0] random_sample();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic send_sample(input logic [7:0] value);
        int gap;
        gap = next_gap(in_run_left, in_run_idle);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample   <= value;
        do @(posedge i_clk); while (!o_in_ready);
        samples_sent++;
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++) send_sample(random_sample());
        frames_run++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [15:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    // Unused upper data bits carry random junk that the block must drop.
    task automatic configure(input logic [11:0] width, input logic [15:0] height,
                             input logic [2:0] chans);
        write_reg(REG_IMAGE_WIDTH, {4'($urandom), width});
        write_reg(REG_IMAGE_HEIGHT, height);
        write_reg(REG_CHANNEL_COUNT, {13'($urandom), chans});
        i_cfg_wr_en <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (o_out_valid && i_out_ready) means_seen <= means_seen + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("[mean_filter_3x3_interleaved] ERROR");
            $finish;
        end
    end

    initial begin
        int gap;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            gap = next_gap(out_run_left, out_run_idle);
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin
        logic [11:0] w_raw;
        logic [15:0] h_raw;
        logic [2:0]  c_raw;
        int          w_eff, h_eff, c_eff;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Width below range with height and channels left at their reset values.
        write_reg(REG_IMAGE_WIDTH, 16'd1);
        i_cfg_wr_en <= 1'b0;
        repeat (4) send_sample(8'd255);
        frames_run++;
        drain();

        write_reg(REG_IMAGE_HEIGHT, 16'd0);
        write_reg(REG_CHANNEL_COUNT, 16'd0);
        i_cfg_wr_en <= 1'b0;
        repeat (4) send_sample(8'd0);
        frames_run++;
        drain();

        configure(12'd3, 16'd3, 3'd1);
        for (int i = 0; i < 9; i++) send_sample((i % 2 == 0) ? 8'd255 : 8'd0);
        frames_run++;
        drain();

        while (random_samples < 64) begin
            w_raw = ($urandom_range(0, 9) == 0) ? 12'($urandom_range(0, 1))
                                                : 12'($urandom_range(2, 5));
            h_raw = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 1))
                                                : 16'($urandom_range(2, 4));
            c_raw = 3'($urandom_range(0, 7));
            w_eff = (w_raw < 12'd2) ? 2 : int'(w_raw);
            h_eff = (h_raw < 16'd2) ? 2 : int'(h_raw);
            c_eff = (c_raw == 3'd0) ? 1 : (c_raw > 3'd4) ? 4 : int'(c_raw);
            configure(w_raw, h_raw, c_raw);
            send_random(w_eff * h_eff * c_eff);
            random_samples += w_eff * h_eff * c_eff;
            drain();
        end

        // Tallest frame setting, cut short at a row boundary by lowering the height.
        write_reg(REG_SPARE, 16'($urandom));
        configure(12'd2, 16'd65535, 3'd1);
        for (int i = 0; i < 10; i++) send_sample(random_sample());
        drain();
        write_reg(REG_IMAGE_HEIGHT, 16'd6);
        i_cfg_wr_en <= 1'b0;
        send_random(2);
        drain();

        $display("Ran %0d frames, %0d samples in and %0d means out,", frames_run, samples_sent,
                 means_seen);
        $display("with widths up to 5, heights up to 65535 and 1 to 4 channels.");
        if (failures == 0) begin
            $display("[mean_filter_3x3_interleaved] OK");
        end else begin
            $display("[mean_filter_3x3_interleaved] ERROR");
        end
        $finish;
    end

endmodule
